// ===== sv/echo_range_median_filter_top_defines.svh =====
// assertion macros shared by the checker
`ifndef ECHO_RANGE_MEDIAN_FILTER_TOP_DEFINES_SVH
`define ECHO_RANGE_MEDIAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ERMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ERMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ermf_pkg.sv =====
package ermf_pkg;

  // fixed field widths
  localparam int DistW   = 14;
  localparam int EchoW   = 16;
  localparam int TimeW   = 32;
  localparam int OffsetW = 22;
  localparam int ProdW   = 32;
  localparam int FullW   = 33;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 22;
  localparam int InDataW = 56;
  localparam int OutDataW = 32;

  typedef logic [CfgIdxW-1:0] cfg_index_t;

  // register indexes
  localparam cfg_index_t RegWindowSize   = 3'd0;
  localparam cfg_index_t RegEchoLimitUs  = 3'd1;
  localparam cfg_index_t RegStaleLimitMs = 3'd2;
  localparam cfg_index_t RegScaleQ16     = 3'd3;
  localparam cfg_index_t RegOffsetQ16    = 3'd4;
  localparam cfg_index_t RegMinDistance  = 3'd5;
  localparam cfg_index_t RegMaxDistance  = 3'd6;

  // register reset values
  localparam logic [3:0]         WindowReset = 4'd5;
  localparam logic [EchoW-1:0]   EchoLimitReset = 16'd35000;
  localparam logic [15:0]        StaleReset = 16'd5000;
  localparam logic [15:0]        ScaleReset = 16'd18589;
  localparam logic [OffsetW-1:0] OffsetReset = 22'd1040840;
  localparam logic [DistW-1:0]   MinDistReset = 14'd320;
  localparam logic [DistW-1:0]   MaxDistReset = 14'd9600;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_CHECK,
    S_MEDIAN,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic check;
    logic med_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept;
    logic med_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/ermf_ctrl.sv =====
module ermf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ermf_pkg::status_t status,
  output ermf_pkg::cmd_t    cmd
);
  import ermf_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_MUL;
      end
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_CHECK;
      S_CHECK: state_next = status.accept ? S_MEDIAN : S_EMIT;
      S_MEDIAN: begin
        if (status.med_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_MUL:    cmd.mul = 1'b1;
      S_ADD:    cmd.add = 1'b1;
      S_CHECK:  cmd.check = 1'b1;
      S_MEDIAN: cmd.med_step = 1'b1;
      S_EMIT:   cmd.emit = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/ermf_datapath.sv =====
module ermf_datapath #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  ermf_pkg::cfg_index_t             cfg_index,
  input  logic [ermf_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [ermf_pkg::InDataW-1:0]     s_tdata,
  input  ermf_pkg::cmd_t                   cmd,
  output ermf_pkg::status_t                status,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [ermf_pkg::OutDataW-1:0]    m_tdata
);
  import ermf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // configuration registers
  logic [3:0]         window_size;
  logic [EchoW-1:0]   echo_limit_us;
  logic [15:0]        stale_limit_ms;
  logic [15:0]        scale_q16;
  logic [OffsetW-1:0] offset_q16;
  logic [DistW-1:0]   min_distance;
  logic [DistW-1:0]   max_distance;

  // per-attempt registers
  logic [EchoW-1:0] dur;
  logic [TimeW-1:0] now_ms;
  logic [ProdW-1:0] prod;
  logic [FullW-1:0] full;
  logic             accepted;

  // window state
  logic [DistW-1:0] sample_ring [MAX_WINDOW];
  logic [SW-1:0]    write_slot;
  logic [CW-1:0]    sample_count;
  logic [TimeW-1:0] last_accept_ms;
  logic             ever_accepted;
  logic [DistW-1:0] held_distance;
  logic [SW-1:0]    med_idx;

  // combinational
  logic [CW-1:0]    eff_window;
  logic [FullW-1:0] lo_bound;
  logic [FullW-1:0] hi_bound;
  logic             accept_now;
  logic [DistW-1:0] dist_now;
  logic [SW-1:0]    slot_use;
  logic [CW-1:0]    slot_inc;
  logic [CW-1:0]    count_clamp;
  logic [DistW-1:0] cand;
  logic [MAX_WINDOW-1:0] lt_mask;
  logic [MAX_WINDOW-1:0] le_mask;
  logic [CW-1:0]    less_cnt;
  logic [CW-1:0]    leq_cnt;
  logic [CW-1:0]    rank;
  logic             med_hit;
  logic [TimeW-1:0] age;
  logic             dist_valid;

  // window size clamped to one through MAX_WINDOW
  always_comb begin
    if (window_size == 4'd0) begin
      eff_window = CW'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      eff_window = CW'(MAX_WINDOW);
    end else begin
      eff_window = CW'(window_size);
    end
  end

  // range check on the scaled distance
  assign lo_bound   = FullW'({min_distance, 16'd0});
  assign hi_bound   = FullW'({max_distance, 16'd0});
  assign accept_now = (dur != '0) && (dur <= echo_limit_us) &&
                      (full >= lo_bound) && (full <= hi_bound);
  assign dist_now   = full[16 +: DistW];

  // ring slot and fill bookkeeping
  assign slot_use    = (CW'(write_slot) >= eff_window) ? '0 : write_slot;
  assign slot_inc    = CW'(slot_use) + CW'(1);
  assign count_clamp = (sample_count > eff_window) ? eff_window : sample_count;

  // rank count of one candidate against the filled entries
  assign cand = sample_ring[med_idx];
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      lt_mask[j] = (32'(j) < 32'(sample_count)) && (sample_ring[j] < cand);
      le_mask[j] = (32'(j) < 32'(sample_count)) && (sample_ring[j] <= cand);
    end
  end
  assign less_cnt = CW'($countones(lt_mask));
  assign leq_cnt  = CW'($countones(le_mask));
  assign rank     = sample_count >> 1;
  assign med_hit  = (less_cnt <= rank) && (rank < leq_cnt);

  // staleness
  assign age        = now_ms - last_accept_ms;
  assign dist_valid = ever_accepted && (age <= TimeW'(stale_limit_ms));

  // status
  assign status.accept   = accept_now;
  assign status.med_last = (CW'(med_idx) + CW'(1)) >= sample_count;
  assign status.out_free = !m_tvalid || m_tready;

  // arithmetic pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur    <= s_tdata[0] ? '0 : s_tdata[16:1];
      now_ms <= s_tdata[48:17];
    end
    if (cmd.mul) begin
      prod <= ProdW'(dur) * ProdW'(scale_q16);
    end
    if (cmd.add) begin
      full <= FullW'(prod) + FullW'(offset_q16);
    end
    if (cmd.check) begin
      accepted <= accept_now;
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.check && accept_now) begin
      sample_ring[slot_use] <= dist_now;
    end
  end

  // window state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WindowReset;
      echo_limit_us  <= EchoLimitReset;
      stale_limit_ms <= StaleReset;
      scale_q16      <= ScaleReset;
      offset_q16     <= OffsetReset;
      min_distance   <= MinDistReset;
      max_distance   <= MaxDistReset;
      write_slot     <= '0;
      sample_count   <= '0;
      last_accept_ms <= '0;
      ever_accepted  <= 1'b0;
      held_distance  <= '0;
      med_idx        <= '0;
    end else begin
      if (cmd.check) begin
        med_idx <= '0;
        if (accept_now) begin
          write_slot     <= (slot_inc >= eff_window) ? '0 : SW'(slot_inc);
          sample_count   <= (count_clamp < eff_window) ? count_clamp + CW'(1)
                                                       : count_clamp;
          last_accept_ms <= now_ms;
          ever_accepted  <= 1'b1;
        end
      end
      if (cmd.med_step) begin
        med_idx <= med_idx + SW'(1);
        if (med_hit) held_distance <= cand;
      end
      if (cfg_valid) begin
        case (cfg_index)
          RegWindowSize: begin
            window_size  <= cfg_data[3:0];
            sample_count <= '0;
            write_slot   <= '0;
          end
          RegEchoLimitUs:  echo_limit_us  <= cfg_data[EchoW-1:0];
          RegStaleLimitMs: stale_limit_ms <= cfg_data[15:0];
          RegScaleQ16:     scale_q16      <= cfg_data[15:0];
          RegOffsetQ16:    offset_q16     <= cfg_data[OffsetW-1:0];
          RegMinDistance:  min_distance   <= cfg_data[DistW-1:0];
          RegMaxDistance:  max_distance   <= cfg_data[DistW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {accepted, dur, dist_valid, held_distance};
    end
  end

endmodule

// ===== sv/echo_range_median_filter_top.sv =====
// Echo ranging with a median filter. Each request on the slave stream is one
// ranging attempt; the echo time is scaled to sixteenths of a centimetre,
// range checked, and an accepted distance enters a window of up to
// MAX_WINDOW samples whose upper median becomes the held distance. One
// result request comes out per attempt. An attempt steps through multiply,
// add and range check, then, when the sample is accepted, a median scan
// with one step per stored sample, and last the output load. The median
// scan rank-counts one candidate sample per cycle against the whole window.
// The next attempt is taken once the result sits in the output register.
// Configuration writes are taken every cycle and belong only to times when
// no attempt is in work; writing the window size empties the window.
module echo_range_median_filter_top #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ermf_pkg::cfg_index_t          cfg_index,
  input  logic [ermf_pkg::CfgDataW-1:0] cfg_data,
  // attempt stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // low to high: echo_timed_out[0], echo_us[16:1], now_ms[48:17], zero pad
  input  logic [ermf_pkg::InDataW-1:0]  s_tdata,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // low to high: distance[13:0], distance_valid[14], last_echo_us[30:15],
  // sample_accepted[31]
  output logic [ermf_pkg::OutDataW-1:0] m_tdata
);
  import ermf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ermf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ermf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/ermf_checker.sv =====
`include "echo_range_median_filter_top_defines.svh"

module ermf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ermf_pkg::OutDataW-1:0] m_tdata
);

  // a held result request keeps its payload
  `ERMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // an attempt that adds a sample is fresh, so the distance is valid
  `ERMF_ASSERT_NOW(a_accept_valid, m_tvalid && m_tdata[31], m_tdata[14], "accepted sample without valid distance")

  // an accepted sample comes from a nonzero echo
  `ERMF_ASSERT_NOW(a_accept_echo, m_tvalid && m_tdata[31], m_tdata[30:15] != 16'd0, "accepted sample with zero echo")

  // one attempt in work at a time
  `ERMF_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second attempt taken while busy")

endmodule

bind echo_range_median_filter_top ermf_checker u_ermf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
